/* hdl/square_tone_channel_macros.svh */
// assertion macros shared by the square tone channel rtl
`ifndef SQUARE_TONE_CHANNEL_MACROS_SVH
`define SQUARE_TONE_CHANNEL_MACROS_SVH

// same-cycle implication, checked outside reset
`define SQTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SQTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sqtc_pkg.sv */
// types and constants of the square tone channel
package sqtc_pkg;

    // transaction kinds
    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_ADVANCE = 2'd1,
        KIND_SAMPLE  = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // register selects
    typedef enum logic [1:0] {
        REG_LEN_DUTY = 2'd0,
        REG_ENVELOPE = 2'd1,
        REG_FREQ_LO  = 2'd2,
        REG_FREQ_HI  = 2'd3
    } t_reg_sel;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV_CHECK,
        ST_ENV_DIV,
        ST_LVL_DIV,
        ST_PHASE_DIV,
        ST_RESULT
    } t_state;

    // shared divider sizes
    localparam int DVD_W = 48;
    localparam int QUO_W = 32;
    localparam int CNT_W = 6;

    // divider step counts
    localparam logic [CNT_W-1:0] STEPS_ENV   = 6'd32;
    localparam logic [CNT_W-1:0] STEPS_LVL   = 6'd20;
    localparam logic [CNT_W-1:0] STEPS_PHASE = 6'd48;

    // fixed scales
    localparam logic [16:0] ENV_ONE       = 17'h10000;
    localparam logic [15:0] LEN_UNIT      = 16'd1000;
    localparam logic [14:0] ENV_STEP_UNIT = 15'd4000;
    localparam logic [11:0] PERIOD_BASE   = 12'd2048;
    localparam int          PHASE_SHIFT   = 17;

    // divider control
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } t_div_ctl;

    // input transaction payload
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  reg_select;
        logic [7:0]  write_data;
        logic [15:0] elapsed;
        logic [30:0] sample_index;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic signed [17:0] sample_value;
        logic               channel_on;
    } t_out_item;

endpackage

/* hdl/sqtc_divider.sv */
// shared restoring divider, one quotient bit per cycle
module sqtc_divider #(
    parameter int DV_W = 27
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sqtc_pkg::t_div_ctl          i_ctl,
    input  logic [sqtc_pkg::DVD_W-1:0]  i_dividend,
    input  logic [DV_W-1:0]             i_divisor,
    output logic                        o_done,
    output logic [sqtc_pkg::QUO_W-1:0]  o_quotient,
    output logic [DV_W-1:0]             o_remainder
);

    logic                        r_busy;
    logic                        r_done;
    logic [sqtc_pkg::CNT_W-1:0]  r_cnt;
    logic [sqtc_pkg::DVD_W-1:0]  r_dvd;
    logic [DV_W-1:0]             r_divisor;
    logic [DV_W-1:0]             r_rem;
    logic [sqtc_pkg::QUO_W-1:0]  r_quo;

    logic [DV_W:0]               trial;
    logic [DV_W:0]               diff;
    logic                        fits;
    logic [DV_W-1:0]             n_rem;

    // trial subtract of the next dividend bit
    always_comb begin
        trial = {r_rem, r_dvd[sqtc_pkg::DVD_W-1]};
        diff  = trial - {1'b0, r_divisor};
        fits  = (trial >= {1'b0, r_divisor});
        n_rem = fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == sqtc_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dvd     <= i_dividend;
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[sqtc_pkg::DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[sqtc_pkg::QUO_W-2:0], fits};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* hdl/square_tone_channel.sv */
// square tone channel: register file, envelope and phase sequencer
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-------------------------
//  input    | i_in_valid   | o_in_ready   | i_in_data  (t_in_item)
//  result   | o_out_valid  | i_out_ready  | o_out_data (t_out_item)
//
// one transaction at a time: a register write goes straight to the result
// state, a time advance takes the envelope check, maybe the step division
// and then the level division, and a sample request takes the phase
// division (48 remainder steps), all on the shared one-bit-per-cycle divider
// reset is synchronous active low and clears all channel state
// a finished result waits in the output register, a stalled result holds
// the sequencer in its result state until the register frees
module square_tone_channel #(
    parameter int SAMPLE_RATE = 44100
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sqtc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sqtc_pkg::t_out_item o_out_data
);

`include "square_tone_channel_macros.svh"

    localparam int P_W  = $clog2(SAMPLE_RATE * 2048 + 1);
    localparam int DV_W = (P_W > 15) ? P_W : 15;
    localparam int CMP_W = DV_W + 3;
    localparam logic [P_W-1:0] RATE_K = P_W'(SAMPLE_RATE);

    // architectural state
    sqtc_pkg::t_state r_state, n_state;
    logic [10:0] r_period_code, n_period_code;
    logic [1:0]  r_duty, n_duty;
    logic [5:0]  r_length, n_length;
    logic        r_one_shot, n_one_shot;
    logic [3:0]  r_env_init, n_env_init;
    logic        r_env_rising, n_env_rising;
    logic [2:0]  r_env_step, n_env_step;
    logic [31:0] r_clock, n_clock;
    logic [16:0] r_env_level, n_env_level;
    logic        r_sounding, n_sounding;

    // work registers
    logic [P_W-1:0]     r_period, n_period;
    logic signed [17:0] r_value, n_value;
    logic               r_out_valid, n_out_valid;
    sqtc_pkg::t_out_item r_out_data, n_out_data;

    // divider link
    sqtc_pkg::t_div_ctl          div_ctl;
    logic [sqtc_pkg::DVD_W-1:0]  div_dividend;
    logic [DV_W-1:0]             div_divisor;
    logic                        div_done;
    logic [sqtc_pkg::QUO_W-1:0]  div_quo;
    logic [DV_W-1:0]             div_rem;

    // helpers
    logic             in_fire;
    logic [32:0]      clock_sum;
    logic [15:0]      len_limit;
    logic [P_W-1:0]   period_calc;
    logic [CMP_W-1:0] p_ext, r1, r2, r4, r8;
    logic             wave_high;
    logic [17:0]      env_pos;

    assign in_fire = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == sqtc_pkg::ST_IDLE);

    // fixed arithmetic around the sequencer
    always_comb begin
        clock_sum   = {1'b0, r_clock} + {17'b0, i_in_data.elapsed};
        len_limit   = 16'((7'd64 - {1'b0, r_length}) * sqtc_pkg::LEN_UNIT);
        period_calc = RATE_K * P_W'(sqtc_pkg::PERIOD_BASE - {1'b0, r_period_code});
        p_ext = CMP_W'(r_period);
        r1    = CMP_W'(div_rem);
        r2    = r1 << 1;
        r4    = r1 << 2;
        r8    = r1 << 3;
        case (r_duty)
            2'd0:    wave_high = (r8 >= p_ext) && (r4 < p_ext);
            2'd1:    wave_high = (r4 < p_ext);
            2'd2:    wave_high = (r2 < p_ext);
            default: wave_high = (r4 >= p_ext);
        endcase
        env_pos = {1'b0, r_env_level};
    end

    // sequencer next state and datapath
    always_comb begin
        n_state       = r_state;
        n_period_code = r_period_code;
        n_duty        = r_duty;
        n_length      = r_length;
        n_one_shot    = r_one_shot;
        n_env_init    = r_env_init;
        n_env_rising  = r_env_rising;
        n_env_step    = r_env_step;
        n_clock       = r_clock;
        n_env_level   = r_env_level;
        n_sounding    = r_sounding;
        n_period      = r_period;
        n_value       = r_value;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_data    = r_out_data;
        div_ctl       = '0;
        div_dividend  = '0;
        div_divisor   = '0;

        case (r_state)
            sqtc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_value = '0;
                    case (sqtc_pkg::t_kind'(i_in_data.kind))
                        sqtc_pkg::KIND_WRITE: begin
                            case (sqtc_pkg::t_reg_sel'(i_in_data.reg_select))
                                sqtc_pkg::REG_LEN_DUTY: begin
                                    n_length = i_in_data.write_data[5:0];
                                    n_duty   = i_in_data.write_data[7:6];
                                end
                                sqtc_pkg::REG_ENVELOPE: begin
                                    n_env_step   = i_in_data.write_data[2:0];
                                    n_env_rising = i_in_data.write_data[3];
                                    n_env_init   = i_in_data.write_data[7:4];
                                end
                                sqtc_pkg::REG_FREQ_LO: begin
                                    n_period_code[7:0] = i_in_data.write_data;
                                end
                                default: begin
                                    n_period_code[10:8] = i_in_data.write_data[2:0];
                                    n_one_shot = i_in_data.write_data[6];
                                    if (i_in_data.write_data[7]) begin
                                        n_clock = '0;
                                    end
                                end
                            endcase
                            n_state = sqtc_pkg::ST_RESULT;
                        end
                        sqtc_pkg::KIND_ADVANCE: begin
                            n_clock = clock_sum[32] ? 32'hFFFF_FFFF : clock_sum[31:0];
                            n_state = sqtc_pkg::ST_ENV_CHECK;
                        end
                        sqtc_pkg::KIND_SAMPLE: begin
                            // remainder of index * 2^17 by the period product
                            n_period      = period_calc;
                            div_ctl.start = 1'b1;
                            div_ctl.steps = sqtc_pkg::STEPS_PHASE;
                            div_dividend  = {i_in_data.sample_index,
                                             {sqtc_pkg::PHASE_SHIFT{1'b0}}};
                            div_divisor   = DV_W'(period_calc);
                            n_state       = sqtc_pkg::ST_PHASE_DIV;
                        end
                        default: begin
                            n_state = sqtc_pkg::ST_RESULT;
                        end
                    endcase
                end
            end

            // one-shot length check and trivial envelopes
            sqtc_pkg::ST_ENV_CHECK: begin
                if (r_one_shot && (r_clock > {16'b0, len_limit})) begin
                    n_sounding = 1'b0;
                    n_state    = sqtc_pkg::ST_RESULT;
                end else begin
                    n_sounding = 1'b1;
                    if (r_env_init == 4'd0) begin
                        n_env_level = '0;
                        n_state     = sqtc_pkg::ST_RESULT;
                    end else if (r_env_step == 3'd0) begin
                        n_env_level = sqtc_pkg::ENV_ONE;
                        n_state     = sqtc_pkg::ST_RESULT;
                    end else begin
                        div_ctl.start = 1'b1;
                        div_ctl.steps = sqtc_pkg::STEPS_ENV;
                        div_dividend  = {r_clock, 16'b0};
                        div_divisor   = DV_W'(15'(r_env_step * sqtc_pkg::ENV_STEP_UNIT));
                        n_state       = sqtc_pkg::ST_ENV_DIV;
                    end
                end
            end

            // step count known, ramp or clamp
            sqtc_pkg::ST_ENV_DIV: begin
                if (div_done) begin
                    if (div_quo < {28'b0, r_env_init}) begin
                        div_ctl.start = 1'b1;
                        div_ctl.steps = sqtc_pkg::STEPS_LVL;
                        div_dividend  = {div_quo[3:0], 16'b0, 28'b0};
                        div_divisor   = DV_W'(r_env_init);
                        n_state       = sqtc_pkg::ST_LVL_DIV;
                    end else begin
                        n_env_level = r_env_rising ? sqtc_pkg::ENV_ONE : 17'd0;
                        n_state     = sqtc_pkg::ST_RESULT;
                    end
                end
            end

            // ramp fraction ready
            sqtc_pkg::ST_LVL_DIV: begin
                if (div_done) begin
                    n_env_level = r_env_rising ? div_quo[16:0]
                                               : sqtc_pkg::ENV_ONE - div_quo[16:0];
                    n_state     = sqtc_pkg::ST_RESULT;
                end
            end

            // phase remainder ready, pick the sign
            sqtc_pkg::ST_PHASE_DIV: begin
                if (div_done) begin
                    n_value = wave_high ? $signed(env_pos) : $signed(18'(18'd0 - env_pos));
                    n_state = sqtc_pkg::ST_RESULT;
                end
            end

            // hand the transaction to the output register
            sqtc_pkg::ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid             = 1'b1;
                    n_out_data.sample_value = r_value;
                    n_out_data.channel_on   = r_sounding;
                    n_state                 = sqtc_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = sqtc_pkg::ST_IDLE;
            end
        endcase
    end

    // control and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sqtc_pkg::ST_IDLE;
            r_period_code <= '0;
            r_duty        <= '0;
            r_length      <= '0;
            r_one_shot    <= 1'b0;
            r_env_init    <= '0;
            r_env_rising  <= 1'b0;
            r_env_step    <= '0;
            r_clock       <= '0;
            r_env_level   <= '0;
            r_sounding    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_period_code <= n_period_code;
            r_duty        <= n_duty;
            r_length      <= n_length;
            r_one_shot    <= n_one_shot;
            r_env_init    <= n_env_init;
            r_env_rising  <= n_env_rising;
            r_env_step    <= n_env_step;
            r_clock       <= n_clock;
            r_env_level   <= n_env_level;
            r_sounding    <= n_sounding;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_period   <= n_period;
        r_value    <= n_value;
        r_out_data <= n_out_data;
    end

    // shared divider
    sqtc_divider #(
        .DV_W (DV_W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    `SQTC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !o_in_ready, "accepted transaction did not leave idle")
    `SQTC_ASSERT_NOW(a_phase_in_range, i_clk, i_rst_n, (r_state == sqtc_pkg::ST_PHASE_DIV) && div_done, div_rem < DV_W'(r_period), "phase remainder not below period")
    `SQTC_ASSERT_NOW(a_env_bounded, i_clk, i_rst_n, 1'b1, r_env_level <= sqtc_pkg::ENV_ONE, "envelope above full scale")

endmodule

/* dv/tb_square_tone_channel.sv */
// self-checking testbench for the square tone channel
module tb_square_tone_channel;
    timeunit 1ns;
    timeprecision 1ps;

    import sqtc_pkg::*;

    localparam int SAMPLE_RATE    = 44100;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 205;
    localparam int BURST_ADVANCES = 40;
    localparam int DRAIN_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // dut connections
    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    square_tone_channel #(
        .SAMPLE_RATE(SAMPLE_RATE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // predicted channel state
    logic [10:0] ch_period_code;
    logic [1:0]  ch_duty;
    logic [5:0]  ch_length;
    logic        ch_one_shot;
    logic [3:0]  ch_env_level;
    logic        ch_env_rising;
    logic [2:0]  ch_env_step;
    logic [31:0] ch_clock;
    logic [16:0] ch_env_out;
    logic        ch_sounding;

    // transactions waiting to be sent and results still owed by the dut
    t_in_item  pending_items[$];
    t_out_item owed_results[$];

    int  error_count = 0;
    int  checked_count = 0;
    int  kind_count[4] = '{0, 0, 0, 0};
    int  sender_wait = 0;
    int  receiver_wait = 0;
    int  sender_calm = 0;
    int  receiver_calm = 0;
    int  idle_cycles = 0;
    bit  no_idling = 1'b0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // expected result of one transaction, updating the predicted state
    function automatic t_out_item predict_tone(t_in_item it);
        t_out_item        res;
        longint unsigned  sum;
        longint unsigned  period;
        longint unsigned  phase;
        int unsigned      limit;
        int unsigned      steps;
        int unsigned      part;
        logic             high;
        res.sample_value = '0;
        case (it.kind)
            KIND_WRITE: begin
                case (it.reg_select)
                    REG_LEN_DUTY: begin
                        ch_length = it.write_data[5:0];
                        ch_duty   = it.write_data[7:6];
                    end
                    REG_ENVELOPE: begin
                        ch_env_step   = it.write_data[2:0];
                        ch_env_rising = it.write_data[3];
                        ch_env_level  = it.write_data[7:4];
                    end
                    REG_FREQ_LO: begin
                        ch_period_code[7:0] = it.write_data;
                    end
                    default: begin
                        ch_period_code[10:8] = it.write_data[2:0];
                        ch_one_shot          = it.write_data[6];
                        if (it.write_data[7]) ch_clock = '0;
                    end
                endcase
            end
            KIND_ADVANCE: begin
                sum = longint'(ch_clock) + longint'(it.elapsed);
                ch_clock = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                limit = (32'd64 - ch_length) * 32'd1000;
                if (ch_one_shot && ch_clock > limit) begin
                    ch_sounding = 1'b0;
                end else begin
                    ch_sounding = 1'b1;
                    if (ch_env_level == 0) begin
                        ch_env_out = '0;
                    end else if (ch_env_step == 0) begin
                        ch_env_out = ENV_ONE;
                    end else begin
                        steps = ch_clock / (32'(ch_env_step) * 32'd4000);
                        if (steps < ch_env_level) begin
                            part = (steps * 32'd65536) / ch_env_level;
                            ch_env_out = ch_env_rising ? 17'(part) : 17'(32'd65536 - part);
                        end else begin
                            ch_env_out = ch_env_rising ? ENV_ONE : 17'd0;
                        end
                    end
                end
            end
            KIND_SAMPLE: begin
                period = longint'(SAMPLE_RATE) * (64'd2048 - ch_period_code);
                phase  = (64'(it.sample_index) << 17) % period;
                case (ch_duty)
                    2'd0:    high = (8 * phase >= period) && (4 * phase < period);
                    2'd1:    high = 4 * phase < period;
                    2'd2:    high = 2 * phase < period;
                    default: high = 4 * phase >= period;
                endcase
                res.sample_value = high ? $signed({1'b0, ch_env_out})
                                        : -$signed({1'b0, ch_env_out});
            end
            default: ;
        endcase
        res.channel_on = ch_sounding;
        return res;
    endfunction

    // per-transaction wait, with occasional runs of back-to-back traffic
    function automatic int draw_wait(inout int calm_left);
        if (no_idling) return 0;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 30);
        return $urandom_range(0, 11);
    endfunction

    function automatic t_in_item make_item(t_kind kind, t_reg_sel sel, logic [7:0] data,
                                           logic [15:0] dt, logic [30:0] idx);
        t_in_item it;
        it.kind         = kind;
        it.reg_select   = sel;
        it.write_data   = data;
        it.elapsed      = dt;
        it.sample_index = idx;
        return it;
    endfunction

    // random transaction with noise in the fields the kind does not use
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        it.kind         = KIND_WRITE;
        it.reg_select   = 2'($urandom);
        it.write_data   = 8'($urandom);
        it.elapsed      = 16'($urandom);
        it.sample_index = 31'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            it.kind = KIND_WRITE;
        end else if (pick < 60) begin
            it.kind = KIND_ADVANCE;
            case ($urandom_range(0, 9))
                0:       it.elapsed = 16'd0;
                1:       it.elapsed = 16'hFFFF;
                2, 3, 4, 5: it.elapsed = 16'($urandom_range(0, 3000));
                6, 7:    it.elapsed = 16'($urandom_range(0, 20000));
                default: ;
            endcase
        end else if (pick < 96) begin
            it.kind = KIND_SAMPLE;
            case ($urandom_range(0, 9))
                0:       it.sample_index = 31'($urandom_range(0, 4096));
                1:       it.sample_index = '1;
                default: ;
            endcase
        end else begin
            it.kind = KIND_NONE;
        end
        return it;
    endfunction

    // wait until every queued transaction is sent and every result is back
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || owed_results.size() != 0)
            @(posedge i_clk);
    endtask

    // driver: presents queued transactions, predicts each one as it is taken
    always @(posedge i_clk) begin : drive_input
        logic busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                owed_results.push_back(predict_tone(i_in_data));
                kind_count[i_in_data.kind]++;
                busy = 1'b0;
                sender_wait = draw_wait(sender_calm);
            end
            if (!busy) begin
                if (sender_wait > 0) begin
                    sender_wait--;
                end else if (pending_items.size() != 0) begin
                    i_in_data <= pending_items.pop_front();
                    busy = 1'b1;
                end
            end
            i_in_valid <= busy;
        end
    end

    // monitor: takes results with random back-pressure and checks them
    always @(posedge i_clk) begin : check_output
        logic      rdy;
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            rdy = i_out_ready;
            if (i_out_ready && o_out_valid) begin
                if (owed_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result: sample %0d on %b", $realtime,
                                 o_out_data.sample_value, o_out_data.channel_on);
                end else begin
                    want = owed_results.pop_front();
                    checked_count++;
                    if (o_out_data.sample_value !== want.sample_value ||
                        o_out_data.channel_on !== want.channel_on) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("[%0t] result %0d: sample %0d on %b, expected %0d on %b",
                                     $realtime, checked_count, o_out_data.sample_value,
                                     o_out_data.channel_on, want.sample_value, want.channel_on);
                    end
                end
                rdy = 1'b0;
                receiver_wait = draw_wait(receiver_calm);
            end
            if (!rdy) begin
                if (receiver_wait > 0) receiver_wait--;
                else rdy = 1'b1;
            end
            i_out_ready <= rdy;
        end
    end

    // watchdog: cycles with work outstanding but no transaction moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (i_out_ready && o_out_valid) ||
            (pending_items.size() == 0 && !i_in_valid && owed_results.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", owed_results.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        ch_period_code = '0;
        ch_duty        = '0;
        ch_length      = '0;
        ch_one_shot    = 1'b0;
        ch_env_level   = '0;
        ch_env_rising  = 1'b0;
        ch_env_step    = '0;
        ch_clock       = '0;
        ch_env_out     = '0;
        ch_sounding    = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset state, extremes, one-shot expiry, trigger, envelope shapes
        pending_items.push_back(make_item(KIND_SAMPLE, REG_LEN_DUTY, 8'h00, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_NONE, REG_FREQ_HI, 8'hFF, 16'hFFFF, '1));
        pending_items.push_back(make_item(KIND_WRITE, REG_ENVELOPE, 8'hF0, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_SAMPLE, REG_LEN_DUTY, 8'h00, 16'h0000, '1));
        pending_items.push_back(make_item(KIND_WRITE, REG_FREQ_LO, 8'hFF, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_WRITE, REG_FREQ_HI, 8'h07, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_WRITE, REG_LEN_DUTY, 8'hC0, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_SAMPLE, REG_LEN_DUTY, 8'h00, 16'h0000, 31'd1));
        pending_items.push_back(make_item(KIND_WRITE, REG_ENVELOPE, 8'h09, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'hFFFF, 31'd0));
        pending_items.push_back(make_item(KIND_WRITE, REG_ENVELOPE, 8'h1F, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'h0001, 31'd0));
        pending_items.push_back(make_item(KIND_WRITE, REG_LEN_DUTY, 8'h3F, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_WRITE, REG_FREQ_HI, 8'hC0, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'd1000, 31'd0));
        pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'd1, 31'd0));
        pending_items.push_back(make_item(KIND_SAMPLE, REG_LEN_DUTY, 8'h00, 16'h0000, 31'd5));
        pending_items.push_back(make_item(KIND_WRITE, REG_FREQ_HI, 8'hB8, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_WRITE, REG_ENVELOPE, 8'hA1, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'd20000, 31'd0));
        pending_items.push_back(make_item(KIND_SAMPLE, REG_LEN_DUTY, 8'h00, 16'h0000, 31'd3));
        pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'hFFFF, 31'd0));
        pending_items.push_back(make_item(KIND_WRITE, REG_FREQ_LO, 8'h00, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_WRITE, REG_FREQ_HI, 8'h00, 16'h0000, 31'd0));
        wait_drained();

        // random phases, the sender holding off until each phase has fully drained
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int k = 0; k < PHASE_ITEMS; k++) pending_items.push_back(random_item());
            wait_drained();
        end

        // back-to-back run of maximal advances, envelope off
        no_idling = 1'b1;
        pending_items.push_back(make_item(KIND_WRITE, REG_ENVELOPE, 8'h00, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_WRITE, REG_FREQ_HI, 8'h80, 16'h0000, 31'd0));
        for (int k = 0; k < BURST_ADVANCES; k++)
            pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'hFFFF,
                                              31'd0));
        wait_drained();
        no_idling = 1'b0;

        // envelope and one-shot behavior on a large clock, then random traffic
        pending_items.push_back(make_item(KIND_WRITE, REG_ENVELOPE, 8'hF7, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_SAMPLE, REG_LEN_DUTY, 8'h00, 16'h0000, 31'd7));
        pending_items.push_back(make_item(KIND_WRITE, REG_ENVELOPE, 8'hFF, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'hFFFF, 31'd0));
        pending_items.push_back(make_item(KIND_WRITE, REG_FREQ_HI, 8'h47, 16'h0000, 31'd0));
        pending_items.push_back(make_item(KIND_ADVANCE, REG_LEN_DUTY, 8'h00, 16'h0001, 31'd0));
        pending_items.push_back(make_item(KIND_SAMPLE, REG_LEN_DUTY, 8'h00, 16'h0000, '1));
        for (int k = 0; k < 40; k++) pending_items.push_back(random_item());
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            error_count++;
            $display("%0d results never arrived", owed_results.size());
        end

        $display("covered %0d writes, %0d time advances, %0d sample requests, %0d no-ops",
                 kind_count[KIND_WRITE], kind_count[KIND_ADVANCE], kind_count[KIND_SAMPLE],
                 kind_count[KIND_NONE]);
        $display("%0d results checked, %0d mismatches", checked_count, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/sqtc_pkg.sv
hdl/sqtc_divider.sv
hdl/square_tone_channel.sv
dv/tb_square_tone_channel.sv
